// ===== design/ilid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_pkg - shared types and constants for the indexed list block
// Opcode and status codes, fixed port widths and the flag group of the
// shared index/compare unit.
// ----------------------------------------------------------------------------
package ilid_pkg;

  localparam int OP_W      = 3;
  localparam int POS_W     = 7;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 7;

  localparam int DEF_CAPACITY      = 64;
  localparam int DEF_ELEMENT_WIDTH = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // compare results of the shared unit
  typedef struct packed {
    logic below;  // idx <  bound
    logic above;  // idx >  bound
    logic hit;    // elem == key
  } unit_flags_t;

endpackage

// ===== design/indexed_list_insert_delete_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_top - bounded ordered list in a two-port store
// Insert, delete, get, locate and clear on a list of up to CAPACITY
// elements, one result item per input item.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_ready is low from acceptance until the
// result is moved into the output register. The list lives in a RAM with one
// write and one registered read port, so every element that moves is first
// read and then written back one place over. The next item may be accepted
// while the previous result still waits for out_ready.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_top #(
  parameter int CAPACITY      = ilid_pkg::DEF_CAPACITY,
  parameter int ELEMENT_WIDTH = ilid_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // input item channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ilid_pkg::OP_W-1:0]     opcode,
  input  logic [ilid_pkg::POS_W-1:0]    position,
  input  logic [ilid_pkg::VALUE_W-1:0]  value_in,
  // result item channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ilid_pkg::STATUS_W-1:0] status,
  output logic [ilid_pkg::VALUE_W-1:0]  data_out,
  output logic [ilid_pkg::COUNT_W-1:0]  count
);
  import ilid_pkg::*;

  // IW addresses the store, CW holds a length 0..CAPACITY
  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,     // range checks, issue first read
    S_UP_RD,     // insert: read element j-1 if j > pos
    S_UP_WR,     // insert: write it to j
    S_INS_WR,    // insert: write new value at pos
    S_DEL_CAP,   // delete: capture removed element
    S_DN_RD,     // delete: read element k if k < length
    S_DN_WR,     // delete: write it to k-1
    S_GET_CAP,   // get: capture element
    S_LOC_RD,    // locate: read element j if j < length
    S_LOC_CMP,   // locate: compare against key
    S_DONE       // wait for a free output register
  } state_t;

  state_t             state;
  op_t                op;
  logic [POS_W-1:0]   pos;
  logic [ELEMENT_WIDTH-1:0] key;
  logic [CW-1:0]      j;          // loop index, wide enough to hold a length 0..CAPACITY
  logic [CW-1:0]      fill;       // current list length
  status_t            res_status;
  logic [VALUE_W-1:0] res_data;

  // element store
  logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] rdata;
  logic [IW-1:0]            rd_addr;
  logic [IW-1:0]            wr_addr;
  logic [ELEMENT_WIDTH-1:0] wdata;
  logic                     mem_we;

  // shared unit
  logic [CW-1:0] u_idx;
  logic [CW-1:0] u_bound;
  logic [CW-1:0] u_next;
  logic [CW-1:0] u_prev;
  unit_flags_t   u_flags;

  logic [IW-1:0] pos_idx;

  assign pos_idx  = IW'(pos);
  assign in_ready = (state == S_IDLE);

  ilid_unit #(
    .IDX_W  (CW),
    .ELEM_W (ELEMENT_WIDTH)
  ) u_unit (
    .idx   (u_idx),
    .bound (u_bound),
    .elem  (rdata),
    .key   (key),
    .flags (u_flags),
    .next  (u_next),
    .prev  (u_prev)
  );

  // operand and store port steering
  always_comb begin
    u_idx   = j;
    u_bound = fill;
    rd_addr = j[IW-1:0];
    mem_we  = 1'b0;
    wr_addr = j[IW-1:0];
    wdata   = rdata;
    unique case (state)
      S_CHECK: begin
        rd_addr = pos_idx;
      end
      S_UP_RD: begin
        // loop runs while j > pos
        u_bound = CW'(pos);
        rd_addr = u_prev[IW-1:0];
      end
      S_UP_WR: begin
        mem_we = 1'b1;
      end
      S_INS_WR: begin
        mem_we  = 1'b1;
        wr_addr = pos_idx;
        wdata   = key;
      end
      S_DEL_CAP: begin
        u_idx = CW'(pos);
      end
      S_DN_WR: begin
        mem_we  = 1'b1;
        wr_addr = u_prev[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= op_t'(opcode);
            pos   <= position;
            key   <= ELEMENT_WIDTH'(value_in);
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_data <= '0;
          unique case (op)
            OP_INSERT: begin
              if (CMPW'(pos) > CMPW'(fill)) begin
                res_status <= ST_BADPOS;
                state      <= S_DONE;
              end else if (fill == CW'(CAPACITY)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                j     <= fill;
                state <= S_UP_RD;
              end
            end
            OP_DELETE: begin
              if (fill == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else if (CMPW'(pos) >= CMPW'(fill)) begin
                res_status <= ST_BADPOS;
                state      <= S_DONE;
              end else begin
                state <= S_DEL_CAP;
              end
            end
            OP_GET: begin
              if (CMPW'(pos) >= CMPW'(fill)) begin
                res_status <= ST_BADPOS;
                state      <= S_DONE;
              end else begin
                state <= S_GET_CAP;
              end
            end
            OP_LOCATE: begin
              j     <= '0;
              state <= S_LOC_RD;
            end
            OP_CLEAR: begin
              fill       <= '0;
              res_status <= ST_OK;
              state      <= S_DONE;
            end
            default: begin
              res_status <= ST_BADPOS;
              state      <= S_DONE;
            end
          endcase
        end
        S_UP_RD: begin
          state <= u_flags.above ? S_UP_WR : S_INS_WR;
        end
        S_UP_WR: begin
          j     <= u_prev;
          state <= S_UP_RD;
        end
        S_INS_WR: begin
          fill       <= CW'(fill + 1'b1);
          res_status <= ST_OK;
          state      <= S_DONE;
        end
        S_DEL_CAP: begin
          res_data <= VALUE_W'(rdata);
          j        <= u_next;
          state    <= S_DN_RD;
        end
        S_DN_RD: begin
          if (u_flags.below) begin
            state <= S_DN_WR;
          end else begin
            fill       <= CW'(fill - 1'b1);
            res_status <= ST_OK;
            state      <= S_DONE;
          end
        end
        S_DN_WR: begin
          j     <= u_next;
          state <= S_DN_RD;
        end
        S_GET_CAP: begin
          res_data   <= VALUE_W'(rdata);
          res_status <= ST_OK;
          state      <= S_DONE;
        end
        S_LOC_RD: begin
          if (u_flags.below) begin
            state <= S_LOC_CMP;
          end else begin
            res_status <= ST_NOTFOUND;
            state      <= S_DONE;
          end
        end
        S_LOC_CMP: begin
          if (u_flags.hit) begin
            res_data   <= VALUE_W'(j);
            res_status <= ST_OK;
            state      <= S_DONE;
          end else begin
            j     <= u_next;
            state <= S_LOC_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= res_status;
            data_out  <= res_data;
            count     <= COUNT_W'(fill);
            state     <= S_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // length never grows past the store
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("list length exceeds capacity");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a second item while busy");

  // store is written only while an item is in work
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != S_IDLE && state != S_DONE && state != S_CHECK))
    else $error("store written outside an operation");

  // a successful insert grows the list by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_WR) |=> (fill == CW'($past(fill) + 1'b1)))
    else $error("insert did not grow the list");

endmodule

// ===== design/ilid_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_unit - shared index step and compare unit
// One incrementer, one decrementer, two magnitude compares and one element
// equality compare, reused by every loop of the sequencer.
// ----------------------------------------------------------------------------
module ilid_unit #(
  parameter int IDX_W  = 7,
  parameter int ELEM_W = 32
) (
  input  logic [IDX_W-1:0]        idx,
  input  logic [IDX_W-1:0]        bound,
  input  logic [ELEM_W-1:0]       elem,
  input  logic [ELEM_W-1:0]       key,
  output ilid_pkg::unit_flags_t   flags,
  output logic [IDX_W-1:0]        next,
  output logic [IDX_W-1:0]        prev
);
  import ilid_pkg::*;

  assign next        = idx + 1'b1;
  assign prev        = idx - 1'b1;
  assign flags.below = (idx < bound);
  assign flags.above = (idx > bound);
  assign flags.hit   = (elem == key);

endmodule
